/* sv/bfba_pkg.sv */
// ----------------------------------------------------------------------------
// bfba_pkg
// Shared constants, codes and controller/datapath interface types for the
// best-fit block allocator.
// ----------------------------------------------------------------------------
package bfba_pkg;

	localparam int TABLE_DEPTH = 16;
	localparam int SLOT_W      = $clog2(TABLE_DEPTH);
	localparam int COUNT_W     = $clog2(TABLE_DEPTH + 1);
	localparam int SIZE_W      = 24;
	localparam int WAIT_W      = 16;
	localparam int MODE_W      = 2;
	localparam int STATUS_W    = 2;
	localparam int OSLOT_W     = 4;
	localparam int IN_DATA_W   = 32;
	localparam int OUT_DATA_W  = 48;

	localparam logic [MODE_W-1:0] MODE_LOAD    = 2'd0;
	localparam logic [MODE_W-1:0] MODE_REQUEST = 2'd1;
	localparam logic [MODE_W-1:0] MODE_CLEAR   = 2'd2;

	localparam logic [STATUS_W-1:0] ST_LOADED  = 2'd0;
	localparam logic [STATUS_W-1:0] ST_GRANTED = 2'd1;
	localparam logic [STATUS_W-1:0] ST_WAIT    = 2'd2;
	localparam logic [STATUS_W-1:0] ST_FULL    = 2'd3;

	localparam logic [WAIT_W-1:0] WAIT_MAX = {WAIT_W{1'b1}};

	typedef struct packed {
		logic capture;   // latch the input item, restart the scan
		logic scan;      // read one table entry, advance the scan index
		logic commit;    // update state and load the output register
	} bfba_cmd_t;

	typedef struct packed {
		logic is_request;
		logic scan_last;
		logic out_busy;
	} bfba_status_t;

	// low bits of a slot number, zero-extended when the table is small
	function automatic logic [OSLOT_W-1:0] slot_field(input logic [SLOT_W-1:0] idx);
		logic [SLOT_W+OSLOT_W-1:0] ext;
		ext = (SLOT_W + OSLOT_W)'(idx);
		return ext[OSLOT_W-1:0];
	endfunction

endpackage

/* sv/best_fit_block_allocator.sv */
// Timing: load, clear and unused mode go from capture straight to commit; a request
// first runs the one-entry-a-cycle scan through the single read port of the block size
// memory, then a drain state for the last compare. Commit waits while the output is stalled.
// Throughput: one item at a time; a new item is accepted only after the previous one
// commits, while its result may still wait in the output register.
// Reset: arst_n clears fill count, used flags, wait count and control at once.
// ----------------------------------------------------------------------------
// best_fit_block_allocator
// Table of block sizes with used flags; grants the smallest unused block that
// fits a request, lowest slot on ties, and counts requests that must wait.
// ----------------------------------------------------------------------------
module best_fit_block_allocator
	import bfba_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [IN_DATA_W-1:0]  s_tdata,   // mode[1:0], size_value[25:2]
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [OUT_DATA_W-1:0] m_tdata    // status[1:0], granted_slot[5:2],
	                                         // granted_size[29:6], waiting_total[45:30]
);

	bfba_cmd_t    cmd;
	bfba_status_t stat;

	bfba_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	bfba_datapath u_datapath (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_mode  (s_tdata[MODE_W-1:0]),
		.in_size  (s_tdata[MODE_W+SIZE_W-1:MODE_W]),
		.cmd      (cmd),
		.stat     (stat),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

endmodule

/* sv/bfba_ctrl.sv */
// ----------------------------------------------------------------------------
// bfba_ctrl
// Sequencer of the allocator: accepts one item, runs the table scan for
// requests and commits the result once the output register is free.
// ----------------------------------------------------------------------------
module bfba_ctrl
	import bfba_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  bfba_status_t stat,
	output bfba_cmd_t    cmd
);

	localparam logic [1:0] S_IDLE  = 2'd0;
	localparam logic [1:0] S_SCAN  = 2'd1;
	localparam logic [1:0] S_DRAIN = 2'd2;
	localparam logic [1:0] S_DONE  = 2'd3;

	logic [1:0] state_q;
	logic [1:0] state_d;

	assign s_tready = (state_q == S_IDLE);

	always_comb begin
		state_d     = state_q;
		cmd.capture = 1'b0;
		cmd.scan    = 1'b0;
		cmd.commit  = 1'b0;
		case (state_q)
			S_IDLE: begin
				if (s_tvalid) begin
					cmd.capture = 1'b1;
					state_d     = stat.is_request ? S_SCAN : S_DONE;
				end
			end
			S_SCAN: begin
				cmd.scan = 1'b1;
				if (stat.scan_last) begin
					state_d = S_DRAIN;
				end
			end
			// last compare lands here
			S_DRAIN: begin
				state_d = S_DONE;
			end
			S_DONE: begin
				if (!stat.out_busy) begin
					cmd.commit = 1'b1;
					state_d    = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	a_commit_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |-> !stat.out_busy)
		else $error("commit while output register stalled");

	a_scan_to_drain: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SCAN && stat.scan_last) |=> state_q == S_DRAIN)
		else $error("scan did not end in drain");

	a_drain_to_done: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_DRAIN |=> state_q == S_DONE)
		else $error("drain did not lead to done");

endmodule

/* sv/bfba_datapath.sv */
// ----------------------------------------------------------------------------
// bfba_datapath
// Block size memory, used flags, counters, best-fit compare unit and the
// output register of the allocator.
// ----------------------------------------------------------------------------
module bfba_datapath
	import bfba_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic [MODE_W-1:0]     in_mode,
	input  logic [SIZE_W-1:0]     in_size,
	input  bfba_cmd_t             cmd,
	output bfba_status_t          stat,
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [OUT_DATA_W-1:0] m_tdata
);

	logic [SIZE_W-1:0]  sizes_mem [TABLE_DEPTH];
	logic [TABLE_DEPTH-1:0] used_q;
	logic [COUNT_W-1:0] count_q;
	logic [WAIT_W-1:0]  wait_q;

	logic [MODE_W-1:0]  mode_q;
	logic [SIZE_W-1:0]  size_q;

	logic [SLOT_W-1:0]  idx_q;
	logic [SLOT_W-1:0]  idx_s1;
	logic               cmp_vld_s1;
	logic [SIZE_W-1:0]  rd_s1;

	logic               found_q;
	logic [SLOT_W-1:0]  best_slot_q;
	logic [SIZE_W-1:0]  best_size_q;

	logic               out_valid_q;
	logic [STATUS_W-1:0] out_status_q;
	logic [OSLOT_W-1:0] out_slot_q;
	logic [SIZE_W-1:0]  out_size_q;
	logic [WAIT_W-1:0]  out_wait_q;

	logic               hit;
	logic               table_full;
	logic [SLOT_W-1:0]  wr_slot;

	assign table_full = (count_q >= COUNT_W'(TABLE_DEPTH));
	assign wr_slot    = count_q[SLOT_W-1:0];

	assign hit = cmp_vld_s1 && !used_q[idx_s1] && (rd_s1 >= size_q)
		&& (!found_q || (rd_s1 < best_size_q));

	assign stat.is_request = (in_mode == MODE_REQUEST);
	assign stat.scan_last  = (idx_q == SLOT_W'(TABLE_DEPTH - 1));
	assign stat.out_busy   = out_valid_q && !m_tready;

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {2'b00, out_wait_q, out_size_q, out_slot_q, out_status_q};

	// block size memory: written on a load commit, read during the scan
	always_ff @(posedge clk) begin
		if (cmd.commit && mode_q == MODE_LOAD && !table_full) begin
			sizes_mem[wr_slot] <= size_q;
		end
		rd_s1 <= sizes_mem[idx_q];
	end

	// item and scan registers
	always_ff @(posedge clk) begin
		idx_s1 <= idx_q;
		if (cmd.capture) begin
			mode_q <= in_mode;
			size_q <= in_size;
		end
		if (hit) begin
			best_slot_q <= idx_s1;
			best_size_q <= rd_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q      <= '0;
			cmp_vld_s1 <= 1'b0;
			found_q    <= 1'b0;
		end else begin
			// entries at or above the fill count are never compared
			cmp_vld_s1 <= cmd.scan && (COUNT_W'(idx_q) < count_q);
			if (cmd.capture) begin
				idx_q   <= '0;
				found_q <= 1'b0;
			end else begin
				if (cmd.scan) begin
					idx_q <= idx_q + SLOT_W'(1);
				end
				if (hit) begin
					found_q <= 1'b1;
				end
			end
		end
	end

	// table state and result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q      <= '0;
			count_q     <= '0;
			wait_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.commit) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
			if (cmd.commit) begin
				case (mode_q)
					MODE_LOAD: begin
						if (!table_full) begin
							used_q[wr_slot] <= 1'b0;
							count_q         <= count_q + COUNT_W'(1);
						end
					end
					MODE_REQUEST: begin
						if (found_q) begin
							used_q[best_slot_q] <= 1'b1;
						end else if (wait_q != WAIT_MAX) begin
							wait_q <= wait_q + WAIT_W'(1);
						end
					end
					MODE_CLEAR: begin
						used_q  <= '0;
						count_q <= '0;
						wait_q  <= '0;
					end
					default: begin
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			case (mode_q)
				MODE_LOAD: begin
					out_status_q <= table_full ? ST_FULL : ST_LOADED;
					out_slot_q   <= '0;
					out_size_q   <= '0;
					out_wait_q   <= wait_q;
				end
				MODE_REQUEST: begin
					out_status_q <= found_q ? ST_GRANTED : ST_WAIT;
					out_slot_q   <= found_q ? slot_field(best_slot_q) : '0;
					out_size_q   <= found_q ? best_size_q : '0;
					out_wait_q   <= (!found_q && wait_q != WAIT_MAX) ?
						wait_q + WAIT_W'(1) : wait_q;
				end
				MODE_CLEAR: begin
					out_status_q <= ST_LOADED;
					out_slot_q   <= '0;
					out_size_q   <= '0;
					out_wait_q   <= '0;
				end
				default: begin
					out_status_q <= ST_LOADED;
					out_slot_q   <= '0;
					out_size_q   <= '0;
					out_wait_q   <= wait_q;
				end
			endcase
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= COUNT_W'(TABLE_DEPTH))
		else $error("fill count beyond table depth");

	a_grant_fits: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.commit && mode_q == MODE_REQUEST && found_q) |-> best_size_q >= size_q)
		else $error("granted block smaller than request");

	a_grant_unused: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.commit && mode_q == MODE_REQUEST && found_q) |->
		(!used_q[best_slot_q] && COUNT_W'(best_slot_q) < count_q))
		else $error("granted slot used or not loaded");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !m_tready) |=> out_valid_q)
		else $error("stalled result dropped");

endmodule

/* verif/tb_best_fit_block_allocator.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_best_fit_block_allocator
// Drives load, request, clear and unused-mode items through the input stream
// and checks every result against a best-fit predictor kept in the bench.
// Covers a directed pass, random allocation sessions and back-to-back
// requests that must wait. Both stream sides idle at random.
// ----------------------------------------------------------------------------
module tb_best_fit_block_allocator;
	import bfba_pkg::*;

	localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;
	localparam int WATCHDOG_LIMIT = 4000;
	localparam int RANDOM_ITEMS   = 1150;
	localparam int BURST_REQUESTS = 40;

	typedef struct {
		logic [MODE_W-1:0] mode;
		logic [SIZE_W-1:0] size;
		bit                drain_first;  // hold until every result is back
		bit                no_gap;
	} alloc_item_t;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [OSLOT_W-1:0]  slot;
		logic [SIZE_W-1:0]   size;
		logic [WAIT_W-1:0]   waits;
	} grant_result_t;

	logic                  clk      = 1'b0;
	logic                  arst_n   = 1'b0;
	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	logic [IN_DATA_W-1:0]  s_tdata  = '0;
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_tdata;

	best_fit_block_allocator u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	always #5 clk = ~clk;

	// predictor state
	logic [SIZE_W-1:0] pool_size  [TABLE_DEPTH];
	bit                pool_taken [TABLE_DEPTH];
	int                pool_fill  = 0;
	logic [WAIT_W-1:0] wait_tally = '0;

	alloc_item_t   alloc_req_q[$];
	grant_result_t grant_q[$];

	bit            in_fire      = 1'b0;
	int            taken_cnt    = 0;
	int            total_items  = 0;
	int            fail_cnt     = 0;
	int            quiet_cycles = 0;
	int            gap_left     = 0;
	int            burst_left   = 0;
	int            stall_left   = 0;
	int            stall_style  = 0;
	bit            launch;
	alloc_item_t   next_item;
	grant_result_t want;

	function automatic grant_result_t allocate_step(input logic [MODE_W-1:0] mode,
	                                                input logic [SIZE_W-1:0] req);
		grant_result_t r;
		int            best;
		bit            found;
		r     = '0;
		best  = 0;
		found = 1'b0;
		r.status = ST_LOADED;
		case (mode)
			MODE_LOAD: begin
				if (pool_fill < TABLE_DEPTH) begin
					pool_size[pool_fill]  = req;
					pool_taken[pool_fill] = 1'b0;
					pool_fill++;
				end else begin
					r.status = ST_FULL;
				end
			end
			MODE_REQUEST: begin
				for (int i = 0; i < pool_fill; i++) begin
					if (!pool_taken[i] && pool_size[i] >= req &&
					    (!found || pool_size[i] < pool_size[best])) begin
						best  = i;
						found = 1'b1;
					end
				end
				if (found) begin
					pool_taken[best] = 1'b1;
					r.status = ST_GRANTED;
					r.slot   = OSLOT_W'(best);
					r.size   = pool_size[best];
				end else begin
					r.status = ST_WAIT;
					if (wait_tally != WAIT_MAX)
						wait_tally++;
				end
			end
			MODE_CLEAR: begin
				for (int i = 0; i < TABLE_DEPTH; i++)
					pool_taken[i] = 1'b0;
				pool_fill  = 0;
				wait_tally = '0;
			end
			default: ;
		endcase
		r.waits = wait_tally;
		return r;
	endfunction

	task automatic add_item(input logic [MODE_W-1:0] mode, input logic [SIZE_W-1:0] size,
	                        input bit drain_first = 1'b0, input bit no_gap = 1'b0);
		alloc_item_t it;
		it.mode        = mode;
		it.size        = size;
		it.drain_first = drain_first;
		it.no_gap      = no_gap;
		alloc_req_q.push_back(it);
	endtask

	// request sizes that mostly land near a block loaded in this session
	function automatic logic [SIZE_W-1:0] pick_request(const ref logic [SIZE_W-1:0] pool[$]);
		int                pick;
		int                sel;
		logic [SIZE_W-1:0] base;
		pick = $urandom_range(0, 99);
		sel  = (pool.size() > 0) ? $urandom_range(0, pool.size() - 1) : 0;
		base = (pool.size() > 0) ? pool[sel] : '0;
		if (pick < 40)
			return base;
		if (pick < 70)
			return (base > 3) ? base - SIZE_W'($urandom_range(0, 3)) : '0;
		if (pick < 85)
			return SIZE_W'($urandom());
		return SIZE_W'($urandom_range(0, 3));
	endfunction

	// input side: bursts with random gaps
	always @(negedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata  <= '0;
			gap_left   = 0;
			burst_left = 0;
		end else if (!s_tvalid || in_fire) begin
			launch = 1'b0;
			if (alloc_req_q.size() > 0 &&
			    !(alloc_req_q[0].drain_first && grant_q.size() > 0)) begin
				if (alloc_req_q[0].no_gap) begin
					launch = 1'b1;
				end else if (gap_left > 0) begin
					gap_left--;
				end else begin
					launch = 1'b1;
					if (burst_left > 0) begin
						burst_left--;
					end else begin
						burst_left = $urandom_range(0, 15);
						gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
					end
				end
			end
			if (launch) begin
				next_item = alloc_req_q.pop_front();
				s_tdata <= {{(IN_DATA_W - MODE_W - SIZE_W){1'b0}}, next_item.size,
				            next_item.mode};
			end
			s_tvalid <= launch;
		end
	end

	// output side: stall style changes every so often
	always @(negedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
			stall_left  = 0;
			stall_style = 0;
		end else begin
			if (stall_left == 0) begin
				stall_style = $urandom_range(0, 2);
				stall_left  = $urandom_range(20, 200);
			end else begin
				stall_left--;
			end
			case (stall_style)
				0:       m_tready <= 1'b1;
				1:       m_tready <= $urandom_range(0, 1);
				default: m_tready <= ($urandom_range(0, 3) == 0);
			endcase
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_fire      = 1'b0;
			quiet_cycles = 0;
		end else begin
			in_fire = s_tvalid && s_tready;
			if (in_fire) begin
				grant_q.push_back(allocate_step(s_tdata[1:0], s_tdata[25:2]));
				taken_cnt++;
			end
			if (m_tvalid && m_tready) begin
				if (grant_q.size() == 0) begin
					$error("result transfer with nothing expected: m_tdata %h", m_tdata);
					fail_cnt++;
				end else begin
					want = grant_q.pop_front();
					if (m_tdata[1:0] !== want.status) begin
						$error("status: expected %0d, actual %0d", want.status, m_tdata[1:0]);
						fail_cnt++;
					end
					if (m_tdata[5:2] !== want.slot) begin
						$error("granted_slot: expected %0d, actual %0d", want.slot,
						       m_tdata[5:2]);
						fail_cnt++;
					end
					if (m_tdata[29:6] !== want.size) begin
						$error("granted_size: expected %0d, actual %0d", want.size,
						       m_tdata[29:6]);
						fail_cnt++;
					end
					if (m_tdata[45:30] !== want.waits) begin
						$error("waiting_total: expected %0d, actual %0d", want.waits,
						       m_tdata[45:30]);
						fail_cnt++;
					end
				end
			end
			if (in_fire || (m_tvalid && m_tready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("Test completed with failures");
				$finish;
			end
		end
	end

	initial begin
		logic [SIZE_W-1:0] session_pool[$];
		logic [SIZE_W-1:0] sz;
		int                counted;
		int                n_load;
		int                n_req;

		// directed: empty table, unused mode, full table, ties, extremes
		add_item(MODE_REQUEST, 24'd5);
		add_item(MODE_UNUSED, 24'hFFFFFF);
		add_item(MODE_LOAD, 24'h000000);
		add_item(MODE_LOAD, 24'hFFFFFF);
		add_item(MODE_LOAD, 24'd100);
		add_item(MODE_LOAD, 24'd50);
		add_item(MODE_LOAD, 24'd100);
		add_item(MODE_LOAD, 24'd300);
		add_item(MODE_LOAD, 24'd7);
		add_item(MODE_LOAD, 24'h800000);
		add_item(MODE_LOAD, 24'h555555);
		add_item(MODE_LOAD, 24'hAAAAAA);
		add_item(MODE_LOAD, 24'd64);
		add_item(MODE_LOAD, 24'd65);
		add_item(MODE_LOAD, 24'd1000);
		add_item(MODE_LOAD, 24'd12);
		add_item(MODE_LOAD, 24'd99);
		add_item(MODE_LOAD, 24'd101);
		add_item(MODE_LOAD, 24'd1);
		add_item(MODE_REQUEST, 24'd0, 1'b1);
		add_item(MODE_REQUEST, 24'hFFFFFF);
		add_item(MODE_REQUEST, 24'd100);
		add_item(MODE_REQUEST, 24'd100);
		add_item(MODE_REQUEST, 24'hFFFFFF);
		add_item(MODE_CLEAR, 24'hFFFFFF, 1'b1);

		// random allocation sessions
		counted = 0;
		while (counted < RANDOM_ITEMS) begin
			if ($urandom_range(0, 9) < 7) begin
				add_item(MODE_CLEAR, SIZE_W'($urandom()));
				session_pool.delete();
				counted++;
			end
			n_load = $urandom_range(1, 18);
			repeat (n_load) begin
				sz = $urandom_range(0, 1) ? SIZE_W'($urandom_range(0, 63)) : SIZE_W'($urandom());
				session_pool.push_back(sz);
				add_item(MODE_LOAD, sz);
				counted++;
			end
			n_req = $urandom_range(1, 20);
			repeat (n_req) begin
				add_item(MODE_REQUEST, pick_request(session_pool),
				         $urandom_range(0, 49) == 0);
				counted++;
				if ($urandom_range(0, 9) == 0) begin
					sz = SIZE_W'($urandom_range(0, 255));
					session_pool.push_back(sz);
					add_item(MODE_LOAD, sz);
					counted++;
				end
				if ($urandom_range(0, 24) == 0)
					add_item(MODE_UNUSED, SIZE_W'($urandom()));
			end
		end

		// back to back requests on an empty table, all of them wait
		add_item(MODE_CLEAR, '0, 1'b1);
		repeat (BURST_REQUESTS)
			add_item(MODE_REQUEST, SIZE_W'($urandom_range(1, 24'hFFFFFF)), 1'b0, 1'b1);
		add_item(MODE_UNUSED, '0);
		add_item(MODE_LOAD, 24'd10);
		add_item(MODE_REQUEST, 24'd11);
		add_item(MODE_REQUEST, 24'd10);
		add_item(MODE_CLEAR, '0);
		add_item(MODE_UNUSED, 24'hFFFFFF);

		total_items = alloc_req_q.size();

		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		do
			@(negedge clk);
		while (taken_cnt < total_items || grant_q.size() != 0);
		repeat (TABLE_DEPTH + 8) @(negedge clk);

		if (fail_cnt == 0 && grant_q.size() == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
